>>> src/pprm_pkg.sv
// Package for the pulse period rpm meter: word types, field widths, opcodes,
// register indexes and the reciprocal constant for the millisecond conversion.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pprm_pkg;

  localparam int TIME_W  = 32;  // timestamps and pulse counter
  localparam int RPM_W   = 30;  // Q26.4 speed
  localparam int PPR_W   = 8;
  localparam int DBNC_W  = 10;
  localparam int TOUT_W  = 16;
  localparam int DEN_W   = TIME_W + PPR_W;  // interval times pulses per rev
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int AVG_DEPTH_DEF = 8;

  // 60e6 us per minute, scaled by 16 for four fraction bits
  localparam logic [RPM_W-1:0] RPM_NUM_Q4 = 30'd960000000;
  localparam logic [DBNC_W-1:0] US_PER_MS = 10'd1000;

  // floor(t / 1000) for any 32-bit t is (t * MS_RECIP) >> MS_SHIFT
  localparam int MS_RECIP_W = 29;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;
  localparam int MS_SHIFT = 38;

  localparam logic [1:0] OP_PULSE  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PPR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [TOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] time_value;
    logic              clear_count;
  } in_word_t;

  typedef struct packed {
    logic [RPM_W-1:0]  rpm_avg_q4;
    logic              new_reading;
    logic [TIME_W-1:0] pulse_count;
    logic              pulse_accepted;
  } out_word_t;

  typedef struct packed {
    logic     capture;      // latch the incoming word
    logic     pulse_eval;   // debounce and record a pulse
    logic     div_start;
    logic     den_load;     // register denominator, timeout flag, ring entry
    logic     rpm_clear;
    logic     rpm_load;
    logic     ring_write;
    logic     avg_mul;      // first half of the average product
    logic     avg_load;
    logic     result_load;
  } pprm_cmd_t;

  typedef struct packed {
    logic timeout;
    logic interval_nz;
    logic div_done;
  } pprm_status_t;

endpackage

`default_nettype wire

>>> src/pprm_div.sv
// Restoring divider, one quotient bit a cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module pprm_div #(
  parameter int DVD_W = 33,
  parameter int DSR_W = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift quotient bits in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");

endmodule

`default_nettype wire

>>> src/pprm_datapath.sv
// Datapath: configuration, pulse timing state, speed ring and result word.
// Depends on pprm_pkg and pprm_div.
`timescale 1ns / 1ps
`default_nettype none

module pprm_datapath
  import pprm_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_word_t              in_data_i,
  input  wire pprm_cmd_t             cmd_i,
  output pprm_status_t               status_o,
  output out_word_t                  out_data_o
);

  localparam int AVG_LOG = $clog2(AVG_DEPTH);
  localparam int SUM_W = RPM_W + AVG_LOG;
  localparam int POS_W = (AVG_DEPTH > 1) ? AVG_LOG : 1;
  localparam int DBUS_W = DBNC_W + DBNC_W;

  // floor(sum / AVG_DEPTH) = (sum * AVG_MUL) >> AVG_SH, exact for any ring sum;
  // the product is split at MUL_LO_W bits and its low part is registered first
  localparam int AVG_SH   = RPM_W + 2 * AVG_LOG;
  localparam int MUL_W    = RPM_W + AVG_LOG + 1;
  localparam int MUL_LO_W = 18;
  localparam int MUL_HI_W = MUL_W - MUL_LO_W;
  localparam longint unsigned AVG_MUL =
    ((64'd1 << AVG_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [MUL_LO_W-1:0] AVG_MUL_LO = MUL_LO_W'(AVG_MUL);
  localparam logic [MUL_HI_W-1:0] AVG_MUL_HI = MUL_HI_W'(AVG_MUL >> MUL_LO_W);
  localparam int LO_PROD_W  = SUM_W + MUL_LO_W;
  localparam int AVG_PROD_W = SUM_W + MUL_W;
  localparam int MS_PROD_W  = TIME_W + MS_RECIP_W;

  logic [PPR_W-1:0]  ppr_q;
  logic [DBNC_W-1:0] debounce_q;
  logic [TOUT_W-1:0] timeout_q;

  in_word_t          item_q;
  logic [TIME_W-1:0] last_us_q;
  logic [TIME_W-1:0] last_ms_q;
  logic [TIME_W-1:0] interval_q;
  logic [TIME_W-1:0] count_q;
  logic [RPM_W-1:0]  rpm_q;
  logic [RPM_W-1:0]  avg_q;
  logic [SUM_W-1:0]  sum_q;
  logic [POS_W-1:0]  pos_q;
  logic              acc_q;
  logic              tout_hit_q;
  logic [DEN_W-1:0]  den_q;
  logic [LO_PROD_W-1:0] avg_lo_q;
  out_word_t         res_q;

  logic [RPM_W-1:0]  ring_mem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] ring_vld_q;
  logic [RPM_W-1:0]  rd_q;
  logic              rd_vld_q;

  logic [TIME_W-1:0] gap;
  logic [DBUS_W-1:0] db_us;
  logic [TIME_W-1:0] since;
  logic [RPM_W-1:0]  old_rpm;
  logic [MS_PROD_W-1:0]  ms_prod;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic              div_done;
  logic [RPM_W-1:0]  div_quot;

  always_comb begin
    gap      = item_q.time_value - last_us_q;
    db_us    = DBUS_W'(debounce_q) * DBUS_W'(US_PER_MS);
    since    = item_q.time_value - last_ms_q;
    old_rpm  = rd_vld_q ? rd_q : '0;
    ms_prod  = MS_PROD_W'(item_q.time_value) * MS_PROD_W'(MS_RECIP);
    avg_prod = ((AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_MUL_HI)) << MUL_LO_W)
             + AVG_PROD_W'(avg_lo_q);
  end

  pprm_div #(
    .DVD_W (RPM_W),
    .DSR_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (RPM_NUM_Q4),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q      <= PPR_W'(1);
      debounce_q <= DBNC_W'(1);
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PPR:      ppr_q <= (cfg_data_i[PPR_W-1:0] == '0) ? PPR_W'(1)
                                                             : cfg_data_i[PPR_W-1:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[DBNC_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TOUT_W-1:0];
        default:      ;
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_us_q  <= '0;
      last_ms_q  <= '0;
      interval_q <= '0;
      count_q    <= '0;
      rpm_q      <= '0;
      avg_q      <= '0;
      sum_q      <= '0;
      pos_q      <= '0;
      acc_q      <= 1'b0;
      tout_hit_q <= 1'b0;
      ring_vld_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        acc_q <= 1'b0;
      end
      if (cmd_i.pulse_eval) begin
        if (last_us_q != '0 && gap > TIME_W'(db_us)) begin
          interval_q <= gap;
          count_q    <= count_q + 1'b1;
          acc_q      <= 1'b1;
        end
        last_us_q <= item_q.time_value;
        last_ms_q <= TIME_W'(ms_prod[MS_PROD_W-1:MS_SHIFT]);
      end
      if (cmd_i.den_load) begin
        tout_hit_q <= since > TIME_W'(timeout_q);
      end
      if (cmd_i.rpm_clear) begin
        rpm_q <= '0;
      end else if (cmd_i.rpm_load) begin
        rpm_q <= div_quot;
      end
      if (cmd_i.ring_write) begin
        sum_q             <= sum_q - SUM_W'(old_rpm) + SUM_W'(rpm_q);
        ring_vld_q[pos_q] <= 1'b1;
        pos_q <= (pos_q == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_q + 1'b1;
      end
      if (cmd_i.avg_load) begin
        avg_q <= avg_prod[AVG_SH +: RPM_W];
      end
      // a count read with clear drops the counter once its value is taken
      if (cmd_i.result_load && item_q.opcode == OP_COUNT && item_q.clear_count) begin
        count_q <= '0;
      end
    end
  end

  // payload registers and ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.den_load) begin
      den_q    <= DEN_W'(interval_q) * DEN_W'(ppr_q);
      rd_q     <= ring_mem[pos_q];
      rd_vld_q <= ring_vld_q[pos_q];
    end
    if (cmd_i.ring_write) begin
      ring_mem[pos_q] <= rpm_q;
    end
    if (cmd_i.avg_mul) begin
      avg_lo_q <= LO_PROD_W'(sum_q) * LO_PROD_W'(AVG_MUL_LO);
    end
    if (cmd_i.result_load) begin
      res_q.rpm_avg_q4     <= avg_q;
      res_q.new_reading    <= count_q != '0;
      res_q.pulse_count    <= count_q;
      res_q.pulse_accepted <= acc_q;
    end
  end

  assign status_o.timeout     = tout_hit_q;
  assign status_o.interval_nz = interval_q != '0;
  assign status_o.div_done    = div_done;
  assign out_data_o           = res_q;

  a_rpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ring_write |-> (rpm_q <= RPM_NUM_Q4))
    else $error("speed above full scale entered the ring");

endmodule

`default_nettype wire

>>> src/pprm_ctrl.sv
// Controller: sequences one word at a time through the datapath and holds
// the result handshake. Depends on pprm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pprm_ctrl
  import pprm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [1:0]   in_opcode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire pprm_status_t status_i,
  output pprm_cmd_t         cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PULSE = 9'b000000010,
    S_UPD   = 9'b000000100,
    S_UMUL  = 9'b000001000,
    S_UDIV  = 9'b000010000,
    S_RING  = 9'b000100000,
    S_AVG   = 9'b001000000,
    S_AVGW  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          case (in_opcode_i)
            OP_PULSE:  state_d = S_PULSE;
            OP_UPDATE: state_d = S_UPD;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_PULSE: begin
        cmd_o.pulse_eval = 1'b1;
        state_d          = S_FIN;
      end
      S_UPD: begin
        cmd_o.den_load = 1'b1;
        state_d        = S_UMUL;
      end
      S_UMUL: begin
        if (status_i.timeout) begin
          cmd_o.rpm_clear = 1'b1;
          state_d         = S_RING;
        end else if (status_i.interval_nz) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_UDIV;
        end else begin
          state_d = S_RING;  // no period yet: keep the previous speed
        end
      end
      S_UDIV: begin
        if (status_i.div_done) begin
          cmd_o.rpm_load = 1'b1;
          state_d        = S_RING;
        end
      end
      S_RING: begin
        cmd_o.ring_write = 1'b1;
        state_d          = S_AVG;
      end
      S_AVG: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = S_AVGW;
      end
      S_AVGW: begin
        cmd_o.avg_load = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before it was taken");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_UDIV))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

>>> src/pulse_period_rpm_meter.sv
// Top level of the pulse period rpm meter: controller, datapath and ports.
// Depends on pprm_pkg, pprm_ctrl and pprm_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Tachometer from pulse periods. Each input word is an opcode with a time value:
// a pulse word (microsecond timestamp) is debounced against debounce_ms and
// records the period since the previous pulse; an update word (millisecond
// timestamp) works out speed = 960000000 / (period * pulses_per_rev) in Q26.4
// rpm, or zero once timeout_ms has passed without a pulse, pushes it into a
// ring of AVG_DEPTH readings and reports the truncated average; a count word
// reports the accepted pulse count and may clear it. Every word gives exactly
// one result word. Words are handled one at a time. The speed division runs on
// a restoring divider that produces one of its 30 quotient bits a cycle; the
// millisecond time of the last pulse and the ring average come from reciprocal
// multiplications by constants, the low part of the average product registered
// first. A count word goes straight to the result stage; a pulse word is
// debounced first; an update word loads the denominator and timeout flag, runs
// the divider unless it has timed out or has no period yet, writes the ring
// and builds the average. The controller is idle again from the edge that
// raises out_valid_o. A finished result sits in an output register, so the
// next word is taken while it waits. The ring has a valid bit per entry,
// cleared at reset, so no clearing pass is needed. Configuration writes are
// always taken and must only be made while the block is idle.
module pulse_period_rpm_meter
  import pprm_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF  // readings averaged, 1 to 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_data_i,
  // result words
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_data_o
);

  pprm_cmd_t    cmd;
  pprm_status_t status;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  pprm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pprm_datapath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/pprm_reading_checker.sv
`timescale 1ns / 1ps
// Checker for the pulse period rpm meter: it mirrors the register writes,
// predicts every result word and compares it field by field.
// Depends on pprm_pkg.
module pprm_reading_checker
  import pprm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_word_t              in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_word_t             out_data_i,
  output int                         fail_count_o,
  output int                         results_waiting_o,
  output int                         results_checked_o,
  output int                         pulses_taken_o,
  output int                         timeouts_seen_o
);

  localparam int RING_DEPTH = AVG_DEPTH_DEF;

  // mirrored registers
  logic [PPR_W-1:0]  pulses_per_rev;
  logic [DBNC_W-1:0] debounce_ms;
  logic [TOUT_W-1:0] timeout_ms;

  // mirrored meter state
  logic [TIME_W-1:0] last_pulse_us;
  logic [TIME_W-1:0] interval_us;
  logic [TIME_W-1:0] pulse_total;
  logic [RPM_W-1:0]  speed_q4;
  logic [RPM_W-1:0]  speed_ring [RING_DEPTH];
  int                ring_pos;
  logic [63:0]       ring_sum;

  out_word_t         due_readings [$];

  // Apply one input word to the mirrored state and return its result word.
  function automatic out_word_t advance_meter(in_word_t w);
    out_word_t   r;
    logic [31:0] gap;
    logic [31:0] since_ms;
    logic [63:0] divisor;
    logic        took;
    took = 1'b0;
    if (w.opcode == OP_PULSE) begin
      if (last_pulse_us != '0) begin
        gap = w.time_value - last_pulse_us;
        if (64'(gap) > 64'(debounce_ms) * 64'(US_PER_MS)) begin
          interval_us = gap;
          pulse_total = pulse_total + 1'b1;
          took = 1'b1;
          pulses_taken_o++;
        end
      end
      // every pulse moves the reference, accepted or not
      last_pulse_us = w.time_value;
    end else if (w.opcode == OP_UPDATE) begin
      since_ms = w.time_value - last_pulse_us / 32'(US_PER_MS);
      if (since_ms > 32'(timeout_ms)) begin
        speed_q4 = '0;
        timeouts_seen_o++;
      end else if (interval_us != '0) begin
        divisor  = 64'(interval_us) * 64'(pulses_per_rev);
        speed_q4 = RPM_W'(64'(RPM_NUM_Q4) / divisor);
      end
      ring_sum             = ring_sum - 64'(speed_ring[ring_pos]) + 64'(speed_q4);
      speed_ring[ring_pos] = speed_q4;
      ring_pos             = (ring_pos + 1) % RING_DEPTH;
    end
    r.rpm_avg_q4     = RPM_W'(ring_sum / RING_DEPTH);
    r.new_reading    = (pulse_total != '0);
    r.pulse_count    = pulse_total;
    r.pulse_accepted = took;
    // the count is reported before the clear takes effect
    if (w.opcode == OP_COUNT && w.clear_count) begin
      pulse_total = '0;
    end
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      pulses_per_rev = PPR_W'(1);
      debounce_ms    = DBNC_W'(1);
      timeout_ms     = TIMEOUT_RST;
      last_pulse_us  = '0;
      interval_us    = '0;
      pulse_total    = '0;
      speed_q4       = '0;
      foreach (speed_ring[i]) speed_ring[i] = '0;
      ring_pos       = 0;
      ring_sum       = '0;
      due_readings.delete();
      fail_count_o      = 0;
      results_checked_o = 0;
      pulses_taken_o    = 0;
      timeouts_seen_o   = 0;
    end else begin
      // results first: a word taken at this edge cannot have its result yet
      if (out_valid_i && out_ready_i) begin
        results_checked_o++;
        if (due_readings.size() == 0) begin
          fail_count_o++;
          $display("%0t: result word %h arrived with nothing expected", $time, out_data_i);
        end else begin
          want = due_readings.pop_front();
          report_field("rpm_avg_q4", 32'(want.rpm_avg_q4), 32'(out_data_i.rpm_avg_q4));
          report_field("new_reading", 32'(want.new_reading), 32'(out_data_i.new_reading));
          report_field("pulse_count", want.pulse_count, out_data_i.pulse_count);
          report_field("pulse_accepted", 32'(want.pulse_accepted),
                       32'(out_data_i.pulse_accepted));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PPR: begin
            pulses_per_rev = cfg_data_i[PPR_W-1:0];
            if (pulses_per_rev == '0) pulses_per_rev = PPR_W'(1);
          end
          CFG_DEBOUNCE: debounce_ms = cfg_data_i[DBNC_W-1:0];
          CFG_TIMEOUT:  timeout_ms  = cfg_data_i[TOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        due_readings.push_back(advance_meter(in_data_i));
      end
    end
    results_waiting_o = due_readings.size();
  end

endmodule

>>> tb/sv/pulse_period_rpm_meter_test.sv
`timescale 1ns / 1ps
// Top of the pulse period rpm meter bench: clock, reset, stimulus and verdict.
// Depends on pprm_pkg, pulse_period_rpm_meter and pprm_reading_checker.
module pulse_period_rpm_meter_test;
  import pprm_pkg::*;

  // opcode the block does not decode; it must report status and change nothing
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int SETTING_ROUNDS = 8;
  localparam int ROUND_WORDS    = 128;  // random words per register setting
  localparam int SWITCH_TX_SLOW = 340;  // random word index where idling swaps
  localparam int SWITCH_NO_IDLE = 680;
  localparam int HOLD_AT        = 700;  // random word index for the long stall
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;

  typedef enum logic [1:0] {
    IDLE_RECV_HEAVY,  // sender rests 10 percent of the time, receiver 80
    IDLE_SEND_HEAVY,  // the other way round
    IDLE_OFF          // both sides always ready
  } idle_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_word;

  int fail_count;
  int results_waiting;
  int results_checked;
  int pulses_taken;
  int timeouts_seen;

  idle_mode_e        stall_mode;
  logic              hold_request;
  logic              hold_done;
  logic [TIME_W-1:0] wall_us;     // time base of the well-formed pulse train
  logic [DBNC_W-1:0] cur_dbnc;
  logic [TOUT_W-1:0] cur_tout;
  int                settings_used;

  pulse_period_rpm_meter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  pprm_reading_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_word),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_word),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting),
    .results_checked_o (results_checked),
    .pulses_taken_o    (pulses_taken),
    .timeouts_seen_o   (timeouts_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a result word.
  initial begin
    #(30_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stall at the rate of the current idling mode, and once, on
  // request, hold off for a long stretch so that the block backs up.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        case (stall_mode)
          IDLE_RECV_HEAVY: out_ready <= ($urandom_range(99) >= 80);
          IDLE_SEND_HEAVY: out_ready <= ($urandom_range(99) >= 10);
          default:         out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one word: rest at random first, then hold valid and payload until
  // taken. Returns at the falling edge after acceptance with valid still high,
  // so back-to-back words need not drop valid.
  task automatic offer_word(in_word_t w);
    while ((stall_mode == IDLE_RECV_HEAVY && $urandom_range(99) < 10) ||
           (stall_mode == IDLE_SEND_HEAVY && $urandom_range(99) < 80)) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic send(logic [1:0] op, logic [TIME_W-1:0] stamp, logic clr);
    in_word_t w;
    w.opcode      = op;
    w.time_value  = stamp;
    w.clear_count = clr;
    offer_word(w);
  endtask

  // Drop valid and wait until every expected result word is back, so the
  // block is idle for a register write or the end of the run.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (results_waiting != 0);
  endtask

  // Write all three registers, one word per handshake.
  task automatic program_meter(logic [15:0] ppr, logic [15:0] dbnc, logic [15:0] tout);
    logic [CFG_IDX_W-1:0]  index [3];
    logic [CFG_DATA_W-1:0] value [3];
    index = '{CFG_PPR, CFG_DEBOUNCE, CFG_TIMEOUT};
    value = '{ppr, dbnc, tout};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= index[i];
      cfg_data  <= value[i];
      do @(posedge clk_i); while (!cfg_ready);
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
    cur_dbnc = dbnc[DBNC_W-1:0];
    cur_tout = tout[TOUT_W-1:0];
    settings_used++;
  endtask

  // One random word. Most words follow a plausible pulse train: gaps around
  // the debounce threshold and updates around the timeout. The rest is noise.
  task automatic send_random_word();
    in_word_t    w;
    int unsigned roll;
    logic [31:0] thr;
    logic [31:0] gap;
    logic [31:0] lag_ms;
    roll          = $urandom_range(99);
    thr           = 32'(cur_dbnc) * 32'(US_PER_MS);
    w.time_value  = $urandom();
    w.clear_count = 1'($urandom_range(1));
    if (roll < 45) begin
      w.opcode = OP_PULSE;
      case ($urandom_range(9))
        0:       gap = thr;                  // exactly on threshold: rejected
        1:       gap = thr + 1;              // just past it
        2:       gap = $urandom_range(thr);  // bounce
        3:       gap = thr + 1 + $urandom_range(50_000_000);  // slow, often times out
        default: gap = thr + 1 + $urandom_range(20_000);
      endcase
      wall_us      = wall_us + gap;
      w.time_value = wall_us;
    end else if (roll < 80) begin
      w.opcode = OP_UPDATE;
      case ($urandom_range(5))
        0:       lag_ms = 32'(cur_tout);      // last moment before timeout
        1:       lag_ms = 32'(cur_tout) + 1;  // first moment after
        default: lag_ms = $urandom_range(32'(cur_tout) + 32'(cur_tout) / 4);
      endcase
      w.time_value = wall_us / 32'(US_PER_MS) + lag_ms;
    end else if (roll < 92) begin
      w.opcode      = OP_COUNT;
      w.clear_count = ($urandom_range(3) == 0);
    end else begin
      w.opcode = 2'($urandom_range(3));
      // a stray pulse moves the block's reference, so follow it
      if (w.opcode == OP_PULSE) wall_us = w.time_value;
    end
    offer_word(w);
  endtask

  initial begin
    logic [15:0] ppr_plan  [SETTING_ROUNDS];
    logic [15:0] dbnc_plan [SETTING_ROUNDS];
    logic [15:0] tout_plan [SETTING_ROUNDS];
    int          word_idx;

    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_word       = '0;
    stall_mode    = IDLE_RECV_HEAVY;
    hold_request  = 1'b0;
    wall_us       = '0;
    cur_dbnc      = DBNC_W'(1);
    cur_tout      = TIMEOUT_RST;
    settings_used = 1;
    word_idx      = 0;

    // register extremes, a zero pulses-per-rev write, and random settings
    ppr_plan  = '{16'd1, 16'd255, 16'd0, 16'($urandom_range(1, 255)),
                  16'($urandom_range(1, 255)), 16'd255, 16'd1,
                  16'($urandom_range(1, 255))};
    dbnc_plan = '{16'd1, 16'd0, 16'd1000, 16'($urandom_range(1000)),
                  16'($urandom_range(1000)), 16'd1000, 16'd0,
                  16'($urandom_range(1000))};
    tout_plan = '{16'd1000, 16'd65535, 16'd1, 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)), 16'd65535, 16'd1,
                  16'($urandom_range(1, 65535))};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at reset settings (debounce 1000 us, timeout 1000 ms).
    send(OP_UPDATE, 32'd0, 1'b0);              // no interval yet: speed held at zero
    send(OP_PULSE, 32'd0, 1'b0);               // no earlier pulse
    send(OP_PULSE, 32'd6000, 1'b0);            // previous pulse time was zero
    send(OP_PULSE, 32'd7000, 1'b0);            // gap equals debounce: rejected
    send(OP_PULSE, 32'd8001, 1'b0);            // gap 1001 us: accepted
    send(OP_UPDATE, 32'd8, 1'b0);
    send(OP_UPDATE, 32'd1008, 1'b0);           // lag equals timeout: still live
    send(OP_UPDATE, 32'd1009, 1'b0);           // past timeout: zero
    send(OP_PULSE, 32'hFFFF_FC00, 1'b1);
    send(OP_PULSE, 32'h0000_0400, 1'b0);       // gap wraps through zero
    send(OP_UPDATE, 32'd0, 1'b0);              // lag wraps negative: timed out
    send(OP_UPDATE, 32'd2, 1'b0);
    send(OP_COUNT, $urandom(), 1'b1);          // report, then clear
    send(OP_COUNT, $urandom(), 1'b0);          // cleared count reads zero
    send(OP_SPARE, 32'hFFFF_FFFF, 1'b1);       // undecoded: no clear
    send(OP_PULSE, 32'hFFFF_FFFF, 1'b1);
    send(OP_UPDATE, 32'hFFFF_FFFF, 1'b1);

    // Zero pulses per rev is taken as one; with no debounce a 1 us period
    // gives full-scale speed, and eight updates fill the ring with it.
    wait_for_quiet();
    program_meter(16'd0, 16'd0, 16'd1);
    send(OP_PULSE, 32'd100, 1'b0);
    send(OP_PULSE, 32'd101, 1'b0);
    repeat (8) send(OP_UPDATE, 32'd0, 1'b0);
    send(OP_UPDATE, 32'd2, 1'b0);              // one past a 1 ms timeout

    for (int round = 0; round < SETTING_ROUNDS; round++) begin
      wait_for_quiet();
      program_meter(ppr_plan[round], dbnc_plan[round], tout_plan[round]);
      // start some pulse trains just below the wrap point
      if ($urandom_range(1)) wall_us = $urandom();
      else wall_us = 32'hFFFF_FFFF - $urandom_range(3_000_000);
      repeat (ROUND_WORDS) begin
        if (word_idx == SWITCH_TX_SLOW) stall_mode <= IDLE_SEND_HEAVY;
        if (word_idx == SWITCH_NO_IDLE) stall_mode <= IDLE_OFF;
        if (word_idx == HOLD_AT) hold_request <= 1'b1;
        send_random_word();
        word_idx++;
      end
    end

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d result words under %0d register settings;", results_checked,
             settings_used);
    $display("%0d pulses passed debounce and %0d updates hit the timeout.", pulses_taken,
             timeouts_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
